### sv/text_console_writer_macros.svh
// Assertion macros shared by the text console RTL.
// TCW_ASSERT checks outside reset; TCW_ASSERT_ALWAYS checks at every edge.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

`ifndef SYNTH
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCW_ASSERT(lbl, prop, msg)
`define TCW_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### sv/tcw_pkg.sv
package tcw_pkg;

  // Field widths of the request and response
  localparam int CMD_W       = 1;
  localparam int CHAR_W      = 8;
  localparam int IDX_W       = 11;
  localparam int ROW_FIELD_W = 5;
  localparam int COL_FIELD_W = 7;
  localparam int CELL_W      = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_PUT  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

  // Character and attribute constants
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h07;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  cell_index;
  } tcw_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0]      read_char;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [COL_FIELD_W-1:0] cursor_col;
  } tcw_rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_DONE
  } tcw_state_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_step;
    logic accept;
    logic latch_read;
    logic scroll_step;
    logic load_out;
  } tcw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_done;
    logic req_read;
    logic req_scroll;
    logic scroll_done;
    logic out_free;
  } tcw_sts_t;

endpackage

### sv/tcw_ram.sv
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/tcw_ctrl.sv
`include "text_console_writer_macros.svh"

module tcw_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  tcw_pkg::tcw_sts_t sts,
  output tcw_pkg::tcw_cmd_t cmd,
  output logic              in_stall
);
  import tcw_pkg::*;

  tcw_state_t state_r;
  tcw_state_t state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clear_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.req_read) begin
            state_nxt = ST_READ;
          end else if (sts.req_scroll) begin
            state_nxt = ST_SCROLL;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_DONE;
      end
      ST_SCROLL: begin
        if (sts.scroll_done) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Commands to the datapath
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
      end
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_READ: begin
        cmd.latch_read = 1'b1;
      end
      ST_SCROLL: begin
        cmd.scroll_step = 1'b1;
      end
      ST_DONE: begin
        cmd.load_out = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `TCW_ASSERT(a_scroll_entry, (state_r == ST_IDLE && in_valid && !sts.req_read && sts.req_scroll) |=> (state_r == ST_SCROLL), "put request needing a scroll did not enter scroll")
  `TCW_ASSERT(a_done_from_scroll, (state_r == ST_SCROLL && sts.scroll_done) |=> (state_r == ST_DONE), "scroll finish did not reach done")
  `TCW_ASSERT_ALWAYS(a_reset_clears, (!rst_n) |=> (state_r == ST_CLEAR), "reset did not start the clearing pass")

endmodule

### sv/tcw_datapath.sv
`include "text_console_writer_macros.svh"

module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tcw_pkg::tcw_req_t in_req,
  input  logic              out_stall,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  tcw_pkg::tcw_cmd_t cmd,
  output tcw_pkg::tcw_sts_t sts,
  output logic              out_valid,
  output tcw_pkg::tcw_rsp_t out_rsp
);
  import tcw_pkg::*;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);

  localparam logic [ROW_W-1:0]  ROW_LAST     = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_LAST     = COL_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] COLS_A       = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] CELL_LAST    = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] SCR_WR_LAST  = ADDR_W'(CELLS - COLUMNS - 1);

  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [7:0]        color_r, color_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [ADDR_W-1:0] scr_cnt_r, scr_cnt_nxt;
  logic              scr_rd_r, scr_rd_nxt;
  logic              scr_wr_r, scr_wr_nxt;
  logic [ADDR_W-1:0] scr_waddr_r, scr_waddr_nxt;
  logic              rd_inrange_r, rd_inrange_nxt;
  logic [CHAR_W-1:0] res_char_r, res_char_nxt;
  logic              out_valid_r, out_valid_nxt;
  tcw_rsp_t          out_rsp_r, out_rsp_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  logic              is_read;
  logic              is_newline;
  logic              put_glyph;
  logic              at_eol;
  logic              at_bottom;
  logic              next_row_req;
  logic [ADDR_W-1:0] cur_addr;
  logic              idx_inrange;

  // Decode the request against the cursor
  assign is_read      = (in_req.cmd == CMD_READ);
  assign is_newline   = (in_req.ch == NEWLINE_CHAR);
  assign put_glyph    = !is_read && !is_newline;
  assign at_eol       = (col_r == COL_LAST);
  assign at_bottom    = (row_r == ROW_LAST);
  assign next_row_req = !is_read && (is_newline || at_eol);
  assign cur_addr     = ADDR_W'(row_r) * COLS_A + ADDR_W'(col_r);
  assign idx_inrange  = (32'(in_req.cell_index) < CELLS);

  // Status to the controller
  assign sts.clear_done  = (clr_cnt_r == CELL_LAST);
  assign sts.req_read    = is_read;
  assign sts.req_scroll  = next_row_req && at_bottom;
  assign sts.scroll_done = scr_wr_r && (scr_waddr_r == SCR_WR_LAST);
  assign sts.out_free    = !out_valid_r || !out_stall;

  // Screen memory ports: clearing pass, scroll copy, or glyph write
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = cur_addr;
    ram_wdata = {color_r, in_req.ch};
    if (cmd.clear_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
      ram_wdata = {RESET_COLOR, BLANK_CHAR};
    end else if (scr_wr_r) begin
      ram_we    = 1'b1;
      ram_waddr = scr_waddr_r;
      ram_wdata = ram_rdata;
    end else if (cmd.accept && put_glyph) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = cmd.scroll_step ? scr_cnt_r : ADDR_W'(in_req.cell_index);

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Cursor, color, scroll sequencing and result
  always_comb begin
    row_nxt        = row_r;
    col_nxt        = col_r;
    color_nxt      = color_r;
    clr_cnt_nxt    = clr_cnt_r;
    scr_cnt_nxt    = scr_cnt_r;
    scr_rd_nxt     = scr_rd_r;
    scr_wr_nxt     = cmd.scroll_step && scr_rd_r;
    scr_waddr_nxt  = scr_cnt_r - COLS_A;
    rd_inrange_nxt = rd_inrange_r;
    res_char_nxt   = res_char_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_rsp_nxt    = out_rsp_r;

    if (cfg_we) begin
      color_nxt = cfg_wdata;
    end

    // Advance the clearing pass
    if (cmd.clear_step && !sts.clear_done) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
    end

    // Take a request
    if (cmd.accept) begin
      res_char_nxt   = '0;
      rd_inrange_nxt = idx_inrange;
      if (next_row_req) begin
        col_nxt = '0;
        if (!at_bottom) begin
          row_nxt = row_r + 1'b1;
        end else begin
          scr_cnt_nxt = COLS_A;
          scr_rd_nxt  = 1'b1;
        end
      end else if (put_glyph) begin
        col_nxt = col_r + 1'b1;
      end
    end

    // Capture the read data
    if (cmd.latch_read) begin
      res_char_nxt = rd_inrange_r ? ram_rdata[CHAR_W-1:0] : '0;
    end

    // Issue scroll reads one row ahead of the writes
    if (cmd.scroll_step && scr_rd_r) begin
      if (scr_cnt_r == CELL_LAST) begin
        scr_rd_nxt = 1'b0;
      end else begin
        scr_cnt_nxt = scr_cnt_r + 1'b1;
      end
    end

    // Load the output register
    if (cmd.load_out) begin
      out_valid_nxt          = 1'b1;
      out_rsp_nxt.read_char  = res_char_r;
      out_rsp_nxt.cursor_row = ROW_FIELD_W'(row_r);
      out_rsp_nxt.cursor_col = COL_FIELD_W'(col_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      color_r     <= RESET_COLOR;
      clr_cnt_r   <= '0;
      scr_rd_r    <= 1'b0;
      scr_wr_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      color_r     <= color_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      scr_rd_r    <= scr_rd_nxt;
      scr_wr_r    <= scr_wr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scr_cnt_r    <= scr_cnt_nxt;
    scr_waddr_r  <= scr_waddr_nxt;
    rd_inrange_r <= rd_inrange_nxt;
    res_char_r   <= res_char_nxt;
    out_rsp_r    <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  `TCW_ASSERT(a_cursor_on_screen, (row_r <= ROW_LAST) && (col_r <= COL_LAST), "cursor left the screen")
  `TCW_ASSERT(a_no_write_clash, !(cmd.clear_step && scr_wr_r) && !(cmd.accept && scr_wr_r), "two sources write the screen at once")
  `TCW_ASSERT(a_result_held, (out_valid_r && out_stall && !cmd.load_out) |=> $stable(out_rsp_r), "stalled result changed")

endmodule

### sv/text_console_writer.sv
// Channel  | Ports                          | Moves
// ---------+--------------------------------+-------------------------------------
// request  | in_valid, in_stall, in_req     | cmd, ch, cell_index
// result   | out_valid, out_stall, out_rsp  | read_char, cursor_row, cursor_col
// config   | cfg_we, cfg_wdata              | text_color
//
// A put or newline request passes from idle to done; a read also passes the read state
// for its registered screen RAM read. A put or newline on the last row adds a scroll,
// one cell copied per cycle through the single write port of the screen RAM.
// After reset a clearing pass fills the screen; in_stall is high.
// The next request is taken while a result waits under out_stall; the block then
// holds its next result until the output register frees.
module text_console_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  tcw_pkg::tcw_req_t in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output tcw_pkg::tcw_rsp_t out_rsp,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);
  import tcw_pkg::*;

  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .sts     (sts),
    .cmd     (cmd),
    .in_stall(in_stall)
  );

  tcw_datapath #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_stall(out_stall),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

endmodule
